### rtl/core/sspb_pkg.sv
// Shared constants and codes for the sweeping servo PWM bank.
// No dependencies; imported by the core, both checkers and the testbench.
package sspb_pkg;

  // default build values
  localparam int CHANNELS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 13;

  // fixed field widths
  localparam int CHAN_IDX_W = 3;
  localparam int STEP_W     = 8;
  localparam int FRAME_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam int PERIOD_TOP_RST      = 4999;
  localparam int WINDOW_START_RST    = 160;
  localparam int WINDOW_END_RST      = 599;
  localparam int STEP_SIZE_RST       = 10;
  localparam int FRAMES_PER_STEP_RST = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_TOP      = 3'd0,
    CFG_WINDOW_START    = 3'd1,
    CFG_WINDOW_END      = 3'd2,
    CFG_STEP_SIZE       = 3'd3,
    CFG_FRAMES_PER_STEP = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

endpackage

### rtl/core/sweeping_servo_pwm_bank.sv
// Sweeping servo PWM bank: frame counter, per-channel pulse compare and sweep.
// Depends on sspb_pkg.
//
// An accepted word's result is registered into the main output slot, or the skid slot.
// Throughput: one word per cycle while the skid slot is empty; the frame/compare/sweep
// logic is one register stage deep, and the two-word output buffer takes one word in a stall.
// Reset: synchronous active-low rst_n clears counters, widths, limits, pins and
// both output slots, and reloads the configuration defaults. cfg_ready is always high.
module sweeping_servo_pwm_bank #(
  parameter int CHANNELS   = sspb_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = sspb_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sspb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sspb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [sspb_pkg::CHAN_IDX_W-1:0] in_channel,
  input  logic [COUNT_BITS-1:0]           in_lower_limit,
  input  logic [COUNT_BITS-1:0]           in_upper_limit,
  input  logic [COUNT_BITS-1:0]           in_start_width,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [CHANNELS-1:0]             out_pin_levels,
  output logic                            out_frame_start
);

  import sspb_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // configuration registers
  logic [COUNT_BITS-1:0] period_top_r;
  logic [COUNT_BITS-1:0] window_start_r;
  logic [COUNT_BITS-1:0] window_end_r;
  logic [STEP_W-1:0]     step_size_r;
  logic [FRAME_W-1:0]    frames_per_step_r;

  // timing and channel state
  logic [COUNT_BITS-1:0] tick_count_r,  tick_count_nxt;
  logic [FRAME_W-1:0]    frame_count_r, frame_count_nxt;
  logic [COUNT_BITS-1:0] pulse_width_r [CHANNELS], pulse_width_nxt [CHANNELS];
  logic [COUNT_BITS-1:0] width_min_r   [CHANNELS], width_min_nxt   [CHANNELS];
  logic [COUNT_BITS-1:0] width_max_r   [CHANNELS], width_max_nxt   [CHANNELS];
  logic [CHANNELS-1:0]   sweep_down_r,  sweep_down_nxt;
  logic [CHANNELS-1:0]   pin_state_r,   pin_state_nxt;

  // output slots: main register plus skid slot
  logic                  out_valid_r,  out_valid_nxt;
  logic [CHANNELS-1:0]   out_pins_r,   out_pins_nxt;
  logic                  out_frame_r,  out_frame_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  logic [CHANNELS-1:0]   skid_pins_r,  skid_pins_nxt;
  logic                  skid_frame_r, skid_frame_nxt;

  // per-item combinational results
  logic                  accept;
  logic                  is_load;
  logic                  at_zero;
  logic                  in_window;
  logic                  frame_end;
  logic                  sweep_now;
  logic [FRAME_W:0]      frame_inc;
  logic [CHANNELS-1:0]   drop;
  logic [COUNT_BITS-1:0] sweep_w [CHANNELS];
  logic [CHANNELS-1:0]   sweep_d;
  logic                  res_frame;

  assign accept    = in_valid && in_ready;
  assign is_load   = (in_operation == OP_LOAD);
  assign at_zero   = (tick_count_r == '0);
  assign in_window = (tick_count_r >= window_start_r) && (tick_count_r < window_end_r);
  assign frame_end = (tick_count_r >= period_top_r);
  assign frame_inc = {1'b0, frame_count_r} + (FRAME_W + 1)'(1);
  // a zero frames_per_step still fires on every frame
  assign sweep_now = frame_end && (frame_inc >= {1'b0, frames_per_step_r});
  assign res_frame = !is_load && at_zero;

  // Per-channel pulse compare and sweep step, all channels side by side.
  always_comb begin
    logic                  down;
    logic [COUNT_BITS-1:0] step_ext;
    logic [COUNT_BITS:0]   up_sum;
    logic [COUNT_BITS-1:0] w_new;
    down     = 1'b0;
    step_ext = COUNT_BITS'(step_size_r);
    up_sum   = '0;
    w_new    = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      drop[n] = (tick_count_r >= pulse_width_r[n]);
      // turn down at or above the upper limit, then move one step
      down   = sweep_down_r[n] || (pulse_width_r[n] >= width_max_r[n]);
      up_sum = {1'b0, pulse_width_r[n]} + {1'b0, step_ext};
      if (down) begin
        w_new = (pulse_width_r[n] > step_ext) ? (pulse_width_r[n] - step_ext) : '0;
      end else begin
        w_new = up_sum[COUNT_BITS] ? COUNT_MAX : up_sum[COUNT_BITS-1:0];
      end
      sweep_w[n] = w_new;
      // turn up again at or below the lower limit
      sweep_d[n] = down && !(w_new <= width_min_r[n]);
    end
  end

  // Next state for one accepted word.
  always_comb begin
    tick_count_nxt  = tick_count_r;
    frame_count_nxt = frame_count_r;
    sweep_down_nxt  = sweep_down_r;
    pin_state_nxt   = pin_state_r;
    for (int n = 0; n < CHANNELS; n++) begin
      pulse_width_nxt[n] = pulse_width_r[n];
      width_min_nxt[n]   = width_min_r[n];
      width_max_nxt[n]   = width_max_r[n];
    end
    if (accept) begin
      if (is_load) begin
        // channels beyond the bank are dropped
        for (int n = 0; n < CHANNELS; n++) begin
          if (32'(in_channel) == n) begin
            width_min_nxt[n]   = in_lower_limit;
            width_max_nxt[n]   = in_upper_limit;
            pulse_width_nxt[n] = in_start_width;
            sweep_down_nxt[n]  = 1'b0;
          end
        end
      end else begin
        // raise all pins at count zero, then apply the cut-off window
        if (at_zero) begin
          pin_state_nxt = '1;
        end
        if (in_window) begin
          pin_state_nxt = pin_state_nxt & ~drop;
        end
        if (frame_end) begin
          tick_count_nxt = '0;
          if (sweep_now) begin
            frame_count_nxt = '0;
            sweep_down_nxt  = sweep_d;
            for (int n = 0; n < CHANNELS; n++) begin
              pulse_width_nxt[n] = sweep_w[n];
            end
          end else begin
            frame_count_nxt = frame_inc[FRAME_W-1:0];
          end
        end else begin
          tick_count_nxt = tick_count_r + COUNT_BITS'(1);
        end
      end
    end
  end

  // Output buffering: fill the main slot when it frees up, spill into the
  // skid slot while the main slot is stalled.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_pins_nxt   = out_pins_r;
    out_frame_nxt  = out_frame_r;
    skid_valid_nxt = skid_valid_r;
    skid_pins_nxt  = skid_pins_r;
    skid_frame_nxt = skid_frame_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_pins_nxt   = skid_pins_r;
        out_frame_nxt  = skid_frame_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_pins_nxt  = pin_state_nxt;
        out_frame_nxt = res_frame;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_pins_nxt  = pin_state_nxt;
      skid_frame_nxt = res_frame;
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_top_r      <= COUNT_BITS'(PERIOD_TOP_RST);
      window_start_r    <= COUNT_BITS'(WINDOW_START_RST);
      window_end_r      <= COUNT_BITS'(WINDOW_END_RST);
      step_size_r       <= STEP_W'(STEP_SIZE_RST);
      frames_per_step_r <= FRAME_W'(FRAMES_PER_STEP_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PERIOD_TOP:      period_top_r      <= cfg_wdata[COUNT_BITS-1:0];
        CFG_WINDOW_START:    window_start_r    <= cfg_wdata[COUNT_BITS-1:0];
        CFG_WINDOW_END:      window_end_r      <= cfg_wdata[COUNT_BITS-1:0];
        CFG_STEP_SIZE:       step_size_r       <= cfg_wdata[STEP_W-1:0];
        CFG_FRAMES_PER_STEP: frames_per_step_r <= cfg_wdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      frame_count_r <= '0;
      sweep_down_r  <= '0;
      pin_state_r   <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
      for (int n = 0; n < CHANNELS; n++) begin
        pulse_width_r[n] <= '0;
        width_min_r[n]   <= '0;
        width_max_r[n]   <= '0;
      end
    end else begin
      tick_count_r  <= tick_count_nxt;
      frame_count_r <= frame_count_nxt;
      sweep_down_r  <= sweep_down_nxt;
      pin_state_r   <= pin_state_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
      for (int n = 0; n < CHANNELS; n++) begin
        pulse_width_r[n] <= pulse_width_nxt[n];
        width_min_r[n]   <= width_min_nxt[n];
        width_max_r[n]   <= width_max_nxt[n];
      end
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    out_pins_r   <= out_pins_nxt;
    out_frame_r  <= out_frame_nxt;
    skid_pins_r  <= skid_pins_nxt;
    skid_frame_r <= skid_frame_nxt;
  end

  assign cfg_ready       = 1'b1;
  assign in_ready        = !skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_pin_levels  = out_pins_r;
  assign out_frame_start = out_frame_r;

endmodule

### rtl/core/sspb_checker.sv
// Port-level checker for the sweeping servo PWM bank, bound to the top level.
// Depends on sspb_pkg.
module sspb_checker #(
  parameter int CHANNELS = sspb_pkg::CHANNELS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [CHANNELS-1:0] out_pin_levels,
  input logic                out_frame_start
);

  import sspb_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pin_levels)
                                && $stable(out_frame_start))
    else $error("stalled result word changed");

  // back-pressure only with a full output slot
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output slot");

  // a word taken into an empty bank shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("accepted word did not produce a result");

  // reset empties both output slots
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("output not empty after reset");

endmodule

bind sweeping_servo_pwm_bank sspb_checker #(
  .CHANNELS(CHANNELS)
) u_sspb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pin_levels  (out_pin_levels),
  .out_frame_start (out_frame_start)
);

### dv/sspb_servo_checker.sv
// Checker for the sweeping servo PWM bank: follows the register, input and result channels,
// predicts each result word and compares it. Depends on sspb_pkg.
module sspb_servo_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [sspb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sspb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_operation,
  input  logic [sspb_pkg::CHAN_IDX_W-1:0]     in_channel,
  input  logic [sspb_pkg::COUNT_BITS_DEF-1:0] in_lower_limit,
  input  logic [sspb_pkg::COUNT_BITS_DEF-1:0] in_upper_limit,
  input  logic [sspb_pkg::COUNT_BITS_DEF-1:0] in_start_width,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [sspb_pkg::CHANNELS_DEF-1:0]   out_pin_levels,
  input  logic                                out_frame_start,
  output int                                  err_count,
  output int                                  queue_depth
);

  import sspb_pkg::*;

  localparam int NCH       = CHANNELS_DEF;
  localparam int COUNT_TOP = (1 << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic [NCH-1:0] pins;
    logic           frame;
  } servo_word_t;

  servo_word_t pending_pins_q[$];
  servo_word_t predicted, observed, wanted;

  int period_top, win_start, win_end, step_size, frames_per_step;
  int tick_count, frame_count;
  int pulse_w[NCH];
  int w_min[NCH];
  int w_max[NCH];
  bit sweep_dn[NCH];
  logic [NCH-1:0] pins_now;
  int mismatches = 0;

  assign err_count = mismatches;

  task automatic clear_state();
    int n;
    period_top      = PERIOD_TOP_RST;
    win_start       = WINDOW_START_RST;
    win_end         = WINDOW_END_RST;
    step_size       = STEP_SIZE_RST;
    frames_per_step = FRAMES_PER_STEP_RST;
    tick_count      = 0;
    frame_count     = 0;
    pins_now        = '0;
    for (n = 0; n < NCH; n++) begin
      pulse_w[n]  = 0;
      w_min[n]    = 0;
      w_max[n]    = 0;
      sweep_dn[n] = 1'b0;
    end
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      CFG_PERIOD_TOP:      period_top      = int'(data[COUNT_BITS_DEF-1:0]);
      CFG_WINDOW_START:    win_start       = int'(data[COUNT_BITS_DEF-1:0]);
      CFG_WINDOW_END:      win_end         = int'(data[COUNT_BITS_DEF-1:0]);
      CFG_STEP_SIZE:       step_size       = int'(data[STEP_W-1:0]);
      CFG_FRAMES_PER_STEP: frames_per_step = int'(data[FRAME_W-1:0]);
      default: ;
    endcase
  endtask

  // Move every width one step; turn at the upper limit before, at the lower limit after.
  task automatic sweep_widths();
    int n, w;
    for (n = 0; n < NCH; n++) begin
      w = pulse_w[n];
      if (w >= w_max[n]) sweep_dn[n] = 1'b1;
      if (sweep_dn[n]) begin
        w = (w > step_size) ? w - step_size : 0;
      end else begin
        w = w + step_size;
        if (w > COUNT_TOP) w = COUNT_TOP;
      end
      if (w <= w_min[n]) sweep_dn[n] = 1'b0;
      pulse_w[n] = w;
    end
  endtask

  task automatic servo_next(input op_t op, input logic [CHAN_IDX_W-1:0] ch,
                            input logic [COUNT_BITS_DEF-1:0] lo, up, sw,
                            output servo_word_t res);
    int c, n;
    logic frame;
    frame = 1'b0;
    if (op == OP_LOAD) begin
      if (ch < NCH) begin
        w_min[ch]    = int'(lo);
        w_max[ch]    = int'(up);
        pulse_w[ch]  = int'(sw);
        sweep_dn[ch] = 1'b0;
      end
    end else begin
      c = tick_count;
      if (c == 0) begin
        pins_now = '1;
        frame    = 1'b1;
      end
      if (c >= win_start && c < win_end) begin
        for (n = 0; n < NCH; n++) begin
          if (c >= pulse_w[n]) pins_now[n] = 1'b0;
        end
      end
      if (c >= period_top) begin
        tick_count  = 0;
        frame_count = frame_count + 1;
        if (frame_count >= frames_per_step) begin
          frame_count = 0;
          sweep_widths();
        end
      end else begin
        tick_count = (c + 1) & COUNT_TOP;
      end
    end
    res.pins  = pins_now;
    res.frame = frame;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      pending_pins_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_wdata);
      // push before pop, so a same-edge result still finds its prediction
      if (in_valid && in_ready) begin
        servo_next(op_t'(in_operation), in_channel, in_lower_limit, in_upper_limit,
                   in_start_width, predicted);
        pending_pins_q.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        observed.pins  = out_pin_levels;
        observed.frame = out_frame_start;
        if (pending_pins_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: result word pins=%b frame=%b with nothing expected",
                     observed.pins, observed.frame);
        end else begin
          wanted = pending_pins_q.pop_front();
          if (observed.pins !== wanted.pins || observed.frame !== wanted.frame) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pins exp=%b got=%b, frame_start exp=%b got=%b",
                       wanted.pins, observed.pins, wanted.frame, observed.frame);
          end
        end
      end
    end
    queue_depth <= pending_pins_q.size();
  end

endmodule

### dv/tb_sweeping_servo_pwm_bank.sv
// Testbench top for the sweeping servo PWM bank: clock, reset, register writes and
// input words with random gaps and result stalls. Depends on sspb_pkg and sspb_servo_checker.
module tb_sweeping_servo_pwm_bank;
  import sspb_pkg::*;

  localparam int CB          = COUNT_BITS_DEF;
  localparam int WIDTH_TOP   = (1 << CB) - 1;
  localparam int CYCLE_LIMIT = 3_000_000;
  // register index that decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                    clk;
  logic                    rst_n           = 1'b0;
  logic                    cfg_valid       = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index       = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata       = '0;
  logic                    in_valid        = 1'b0;
  logic                    in_ready;
  logic                    in_operation    = 1'b0;
  logic [CHAN_IDX_W-1:0]   in_channel      = '0;
  logic [CB-1:0]           in_lower_limit  = '0;
  logic [CB-1:0]           in_upper_limit  = '0;
  logic [CB-1:0]           in_start_width  = '0;
  logic                    out_valid;
  logic                    out_ready       = 1'b0;
  logic [CHANNELS_DEF-1:0] out_pin_levels;
  logic                    out_frame_start;

  int err_count;
  int queue_depth;
  int cycle_count  = 0;
  int ready_left   = 0;
  int ready_roll;
  bit drain_steady = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  sweeping_servo_pwm_bank u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_channel      (in_channel),
    .in_lower_limit  (in_lower_limit),
    .in_upper_limit  (in_upper_limit),
    .in_start_width  (in_start_width),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pin_levels  (out_pin_levels),
    .out_frame_start (out_frame_start)
  );

  sspb_servo_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_channel      (in_channel),
    .in_lower_limit  (in_lower_limit),
    .in_upper_limit  (in_upper_limit),
    .in_start_width  (in_start_width),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pin_levels  (out_pin_levels),
    .out_frame_start (out_frame_start),
    .err_count       (err_count),
    .queue_depth     (queue_depth)
  );

  // Result-side back-pressure: short stalls mostly, a few long ones, and long
  // open stretches so the output buffer also sees full speed.
  always @(posedge clk) begin
    if (drain_steady) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 45) begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(0, 6);
      end else if (ready_roll < 55) begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(50, 200);
      end else if (ready_roll < 92) begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(0, 3);
      end else begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(10, 40);
      end
    end
  end

  // Hard stop in case a word or result never gets through.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL sweeping_servo_pwm_bank");
      $finish;
    end
  end

  // Idle length before the next word: mostly none, often short, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word and hold it until accepted; valid stays high on return.
  task automatic send_word(input op_t op, input logic [CHAN_IDX_W-1:0] ch,
                           input logic [CB-1:0] lo, up, sw, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_channel     <= ch;
    in_lower_limit <= lo;
    in_upper_limit <= up;
    in_start_width <= sw;
    do @(posedge clk); while (!in_ready);
  endtask

  // Tick with junk in the load fields, which a tick ignores.
  task automatic send_tick(input int gap);
    send_word(OP_TICK, CHAN_IDX_W'($urandom), CB'($urandom), CB'($urandom), CB'($urandom), gap);
  endtask

  // Write one register; random junk goes above the register's own width.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk      = $urandom;
    junk      = junk << width;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value) | junk;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain all pending results, then rewrite every register.
  task automatic program_regs(input int top, ws, we, ss, fps);
    do @(posedge clk); while (queue_depth != 0);
    write_reg(CFG_PERIOD_TOP, top, CB);
    write_reg(CFG_WINDOW_START, ws, CB);
    write_reg(CFG_WINDOW_END, we, CB);
    write_reg(CFG_SPARE_IDX, $urandom, 0);
    write_reg(CFG_STEP_SIZE, ss, STEP_W);
    write_reg(CFG_FRAMES_PER_STEP, fps, FRAME_W);
    cfg_valid <= 1'b0;
  endtask

  // One phase of random words under one register setting. Most loads are
  // well formed (lower <= start <= upper, near the cut-off window); the rest are noise.
  task automatic run_phase(input bit reprogram, input int top, ws, we, ss, fps,
                           input int words, input int load_pct, input bit calm);
    int k, hi_w;
    bit is_load;
    logic [CHAN_IDX_W-1:0] ch;
    logic [CB-1:0] lo, up, sw;
    if (reprogram) program_regs(top, ws, we, ss, fps);
    drain_steady <= calm;
    hi_w = ((we < top) ? we : top) + 2;
    if (hi_w > WIDTH_TOP) hi_w = WIDTH_TOP;
    for (k = 0; k < words; k++) begin
      is_load = ($urandom_range(0, 99) < load_pct);
      ch = $urandom;
      lo = $urandom;
      up = $urandom;
      sw = $urandom;
      if (is_load && $urandom_range(0, 7) != 0) begin
        lo = $urandom_range(0, hi_w);
        up = $urandom_range(int'(lo), hi_w);
        sw = $urandom_range(int'(lo), int'(up));
      end
      send_word(is_load ? OP_LOAD : OP_TICK, ch, lo, up, sw, calm ? 0 : pick_gap());
    end
    in_valid <= 1'b0;
  endtask

  // Short frame, window from zero, full step, zero frames_per_step (acts as one).
  task automatic directed_words();
    int k;
    program_regs(3, 0, 4, 255, 0);
    drain_steady <= 1'b0;
    send_word(OP_LOAD, 3'd0, '0, CB'(WIDTH_TOP), CB'(WIDTH_TOP), 0);  // starts at upper: turns down
    send_word(OP_LOAD, 3'd7, CB'(WIDTH_TOP), '0, CB'(4000), 0);        // swapped limits
    send_word(OP_LOAD, 3'd3, CB'(100), CB'(WIDTH_TOP), CB'(8100), 1);  // saturates at the top
    send_word(OP_LOAD, 3'd1, '0, '0, '0, 0);                           // zero width drops at once
    send_word(OP_LOAD, 3'd2, '0, CB'(200), CB'(200), 2);               // step below zero clamps
    send_word(OP_LOAD, 3'd4, CB'(2), CB'(3), CB'(2), 0);
    send_word(OP_LOAD, 3'd5, CB'(1), CB'(1), CB'(1), 0);               // off the step grid
    send_word(OP_LOAD, 3'd6, '0, CB'(WIDTH_TOP), CB'(3), 0);
    for (k = 0; k < 14; k++) send_tick(pick_gap());
    // load mid-frame: pins must hold
    send_word(OP_LOAD, 3'd0, CB'(1), CB'(2), CB'(1), 0);
    send_tick(0);
    send_tick(0);
    in_valid <= 1'b0;
  endtask

  initial begin
    int p, pt, ws, we;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: enough ticks to cross the default window
    run_phase(1'b0, PERIOD_TOP_RST, WINDOW_START_RST, WINDOW_END_RST, STEP_SIZE_RST,
              FRAMES_PER_STEP_RST, 650, 4, 1'b0);
    directed_words();
    // zero period: every tick starts and ends a frame
    run_phase(1'b1, 0, 0, 1, 1, 1, 150, 10, 1'b0);
    // longest frame, window over the whole count
    run_phase(1'b1, WIDTH_TOP, 0, WIDTH_TOP, 200, 1, 150, 10, 1'b1);
    run_phase(1'b1, 9, 2, 8, 7, 3, 200, 12, 1'b0);
    run_phase(1'b1, 40, 5, 35, 1, 65535, 150, 8, 1'b0);
    // empty window: no pin is ever dropped
    run_phase(1'b1, 25, WIDTH_TOP, 0, 13, 2, 100, 10, 1'b0);
    run_phase(1'b1, 30, 0, WIDTH_TOP, 37, 1, 150, 10, 1'b1);
    run_phase(1'b1, 1, 0, 2, 3, 1, 100, 15, 1'b0);
    for (p = 0; p < 8; p++) begin
      pt = $urandom_range(0, 60);
      ws = $urandom_range(0, pt + 4);
      we = $urandom_range(0, pt + 6);
      run_phase(1'b1, pt, ws, we,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12),
                $urandom_range(0, 4), 40, 10, ($urandom_range(0, 3) == 0));
    end

    // drain, then let the pipeline settle before the verdict
    do @(posedge clk); while (queue_depth != 0);
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("PASS sweeping_servo_pwm_bank");
    else
      $display("FAIL sweeping_servo_pwm_bank");
    $finish;
  end

endmodule
